FILE: design/cwc_pkg.sv
package cwc_pkg;

   localparam int TableDepth = 4096;
   localparam int AddrWidth = $clog2(TableDepth);
   localparam int CountWidth = AddrWidth + 1;
   localparam int NumWindows = 4;
   localparam int KeyWidth = 40;
   localparam int AttrWidth = 41;
   localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
   localparam logic [15:0] TotalWindowTop = 16'd64000;
   localparam int BinShift = 3;

   typedef enum logic [2:0] {
      REQ_LOAD_ENTRY  = 3'd0,
      REQ_LOAD_WINDOW = 3'd1,
      REQ_FLIGHT      = 3'd2,
      REQ_REPORT      = 3'd3,
      REQ_CLEAR_TABLE = 3'd4
   } req_code_type;

   localparam logic [2:0] CSR_CENTER_X = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y = 3'd1;
   localparam logic [2:0] CSR_RADIUS = 3'd2;
   localparam logic [2:0] CSR_ANGLE_MIN = 3'd3;
   localparam logic [2:0] CSR_ANGLE_MAX = 3'd4;

   // One classified command as it sits in the queue between front and back.
   typedef struct packed {
      logic [2:0]  code;
      logic [39:0] key;
      logic [40:0] attr;
      logic [1:0]  window_index;
      logic [12:0] window_low;
      logic [12:0] window_high;
      logic [15:0] channel;
   } cmd_type;

   typedef struct packed {
      logic [11:0] center_x;
      logic [11:0] center_y;
      logic [12:0] radius;
      logic signed [8:0] angle_min;
      logic signed [8:0] angle_max;
   } csr_type;

endpackage

FILE: design/cwc_front.sv
module cwc_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_type,
   input  logic [15:0] file_number,
   input  logic [23:0] frame_number,
   input  logic [11:0] pos_x,
   input  logic [11:0] pos_y,
   input  logic signed [16:0] axis_angle,
   input  logic [1:0] window_index,
   input  logic [12:0] window_low,
   input  logic [12:0] window_high,
   input  logic [15:0] flight_channel,
   output logic q_valid,
   input  logic q_ready,
   output cwc_pkg::cmd_type q_cmd
);

   // Two-entry queue; unused codes are dropped here.
   cwc_pkg::cmd_type mem_ff [2];
   logic [1:0] fill_ff;
   logic rd_ff, wr_ff;
   logic push, pop, useful;
   cwc_pkg::cmd_type cmd_in;

   always_comb begin
      cmd_in.code = req_type;
      cmd_in.key = {file_number, frame_number};
      cmd_in.attr = {pos_x, pos_y, axis_angle};
      cmd_in.window_index = window_index;
      cmd_in.window_low = window_low;
      cmd_in.window_high = window_high;
      cmd_in.channel = flight_channel;
   end

   assign useful = (req_type <= 3'(cwc_pkg::REQ_CLEAR_TABLE));
   assign req_ready = (fill_ff != 2'd2);
   assign push = req_valid && req_ready && useful;
   assign q_valid = (fill_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_cmd = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= cmd_in;
      if (reset) begin
         fill_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

FILE: design/cwc_accept.sv
module cwc_accept (
   input  logic clock,
   input  logic [40:0] attr,
   input  cwc_pkg::csr_type csr,
   output logic ok_ff
);

   // Two stages: squares and the angle compare registered, then the sum and the radius compare.
   logic signed [12:0] dx, dy;
   logic [23:0] dx2_ff, dy2_ff;
   logic [25:0] r2_ff;
   logic ang_ok_ff;
   logic signed [16:0] ang;
   logic signed [17:0] lo, hi;

   assign dx = $signed({1'b0, attr[40:29]}) - $signed({1'b0, csr.center_x});
   assign dy = $signed({1'b0, attr[28:17]}) - $signed({1'b0, csr.center_y});
   assign ang = attr[16:0];
   assign lo = 18'($signed({csr.angle_min, 8'd0}));
   assign hi = 18'($signed({csr.angle_max, 8'd0}));

   logic [25:0] r2_full;
   assign r2_full = 26'(csr.radius * csr.radius);

   always_ff @(posedge clock) begin
      dx2_ff <= 24'(dx * dx);
      dy2_ff <= 24'(dy * dy);
      r2_ff <= r2_full;
      ang_ok_ff <= (18'(ang) >= lo) && ($signed(18'(ang)) < hi) && ($signed(18'(ang)) >= lo);
      ok_ff <= ang_ok_ff && ({2'b0, dx2_ff} + {2'b0, dy2_ff} < r2_ff);
   end

endmodule

FILE: design/cwc_back.sv
module cwc_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  cwc_pkg::cmd_type q_cmd,
   input  cwc_pkg::csr_type csr,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] count_kind,
   output logic [31:0] count_value,
   output logic last
);

   localparam int AW = cwc_pkg::AddrWidth;
   localparam int CW = cwc_pkg::CountWidth;
   localparam int NW = cwc_pkg::NumWindows;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_READ, ST_TEST, ST_SCAN, ST_EMIT
   } state_type;

   logic [cwc_pkg::KeyWidth-1:0] key_mem [cwc_pkg::TableDepth];
   logic [cwc_pkg::AttrWidth-1:0] attr_mem [cwc_pkg::TableDepth];
   logic [cwc_pkg::KeyWidth-1:0] key_rd_ff;
   logic [cwc_pkg::AttrWidth-1:0] attr_rd_ff;

   state_type state_ff;
   cwc_pkg::cmd_type cmd_ff;
   logic [CW-1:0] entry_count_ff;
   logic [15:0] win_lo_ff [NW];
   logic [15:0] win_hi_ff [NW];
   logic [31:0] cnt_ff [NW+1];
   logic [31:0] inc_ff;
   logic signed [CW:0] left_ff, right_ff;
   logic [CW-1:0] scan_ff;
   logic [CW-1:0] seen_ff;
   logic [3:0] wait_ff;
   logic [2:0] emit_ff;
   logic rsp_valid_ff;
   logic [2:0] kind_ff;
   logic [31:0] value_ff;
   logic last_ff;
   logic [AW-1:0] rd_addr;
   logic ok;
   logic signed [CW:0] mid;

   cwc_accept u_accept (.clock(clock), .attr(attr_rd_ff), .csr(csr), .ok_ff(ok));

   assign mid = (left_ff + right_ff) >>> 1;
   assign q_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign count_kind = kind_ff;
   assign count_value = value_ff;
   assign last = last_ff;

   always_comb begin
      if (state_ff == ST_SCAN) rd_addr = scan_ff[AW-1:0];
      else rd_addr = mid[AW-1:0];
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[rd_addr];
      attr_rd_ff <= attr_mem[rd_addr];
      if (state_ff == ST_IDLE && q_valid && q_cmd.code == 3'(cwc_pkg::REQ_LOAD_ENTRY)
          && entry_count_ff < CW'(cwc_pkg::TableDepth)) begin
         key_mem[entry_count_ff[AW-1:0]] <= q_cmd.key;
         attr_mem[entry_count_ff[AW-1:0]] <= q_cmd.attr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_count_ff <= '0;
         for (int i = 0; i < NW; i++) begin
            win_lo_ff[i] <= '0;
            win_hi_ff[i] <= '0;
         end
         for (int i = 0; i <= NW; i++) cnt_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
         inc_ff <= '0;
         left_ff <= '0;
         right_ff <= '0;
         scan_ff <= '0;
         seen_ff <= '0;
         wait_ff <= '0;
         emit_ff <= '0;
         cmd_ff <= '0;
         kind_ff <= '0;
         value_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         if (state_ff != ST_EMIT && rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_cmd;
                  case (q_cmd.code)
                     3'(cwc_pkg::REQ_LOAD_ENTRY): begin
                        if (entry_count_ff < CW'(cwc_pkg::TableDepth))
                           entry_count_ff <= entry_count_ff + 1'b1;
                     end
                     3'(cwc_pkg::REQ_LOAD_WINDOW): begin
                        if (32'(q_cmd.window_index) < NW) begin
                           win_lo_ff[q_cmd.window_index] <=
                              {q_cmd.window_low, cwc_pkg::BinShift'(0)};
                           win_hi_ff[q_cmd.window_index] <=
                              {q_cmd.window_high, cwc_pkg::BinShift'(0)};
                        end
                     end
                     3'(cwc_pkg::REQ_FLIGHT): begin
                        left_ff <= '0;
                        right_ff <= $signed({1'b0, entry_count_ff}) - 2'sd1;
                        state_ff <= ST_SEARCH;
                     end
                     3'(cwc_pkg::REQ_REPORT): begin
                        scan_ff <= '0;
                        seen_ff <= '0;
                        inc_ff <= '0;
                        wait_ff <= '0;
                        state_ff <= ST_SCAN;
                     end
                     3'(cwc_pkg::REQ_CLEAR_TABLE): entry_count_ff <= '0;
                     default: ;
                  endcase
               end
            end
            ST_SEARCH: begin
               if (left_ff > right_ff) state_ff <= ST_IDLE;
               else state_ff <= ST_READ;
            end
            ST_READ: begin
               if (key_rd_ff == cmd_ff.key) begin
                  wait_ff <= '0;
                  state_ff <= ST_TEST;
               end else begin
                  if (key_rd_ff < cmd_ff.key) left_ff <= mid + 2'sd1;
                  else right_ff <= mid - 2'sd1;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_TEST: begin
               wait_ff <= wait_ff + 1'b1;
               if (wait_ff == 4'd2) begin
                  if (ok) begin
                     for (int i = 0; i < NW; i++)
                        if (win_lo_ff[i] <= cmd_ff.channel && cmd_ff.channel < win_hi_ff[i]
                            && cnt_ff[i] != cwc_pkg::CountMax)
                           cnt_ff[i] <= cnt_ff[i] + 1'b1;
                     if (cmd_ff.channel < cwc_pkg::TotalWindowTop
                         && cnt_ff[NW] != cwc_pkg::CountMax)
                        cnt_ff[NW] <= cnt_ff[NW] + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               // Address issued at scan_ff; verdict via attr_rd_ff and the accept stages.
               // Only the verdicts of loaded entries are counted.
               if (scan_ff < entry_count_ff) scan_ff <= scan_ff + 1'b1;
               if (wait_ff < 4'd3) wait_ff <= wait_ff + 1'b1;
               else if (seen_ff < entry_count_ff) begin
                  if (ok && inc_ff != cwc_pkg::CountMax) inc_ff <= inc_ff + 1'b1;
                  seen_ff <= seen_ff + 1'b1;
               end else state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  kind_ff <= emit_ff;
                  last_ff <= (emit_ff == 3'(NW + 1));
                  if (emit_ff == 3'd0) value_ff <= inc_ff;
                  else begin
                     value_ff <= cnt_ff[emit_ff - 1'b1];
                     cnt_ff[emit_ff - 1'b1] <= '0;
                  end
                  if (emit_ff == 3'(NW + 1)) begin
                     emit_ff <= '0;
                     state_ff <= ST_IDLE;
                  end else emit_ff <= emit_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: design/coincidence_window_counter_core.sv
// Coincidence window counter. Image entries (key, position, axis angle) must
// be loaded by the user in ascending key order; the block does not enforce it.
// Each flight event binary-searches the table for its key and, if the entry
// lies in the angle window and inside the acceptance circle, bumps every
// channel window holding its channel and the total window below 64000. A
// report scans the table for the incident count and returns six items
// (incident, four windows, total; last on the total), clearing the counters.
// A flight event probes the table through its single read port once per
// search step and then runs the acceptance test; a report reads every loaded
// entry. A two-item queue lets new requests be taken while the back end works.
module coincidence_window_counter_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_type,
   input  logic [15:0] file_number,
   input  logic [23:0] frame_number,
   input  logic [11:0] pos_x,
   input  logic [11:0] pos_y,
   input  logic signed [16:0] axis_angle,
   input  logic [1:0] window_index,
   input  logic [12:0] window_low,
   input  logic [12:0] window_high,
   input  logic [15:0] flight_channel,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] count_kind,
   output logic [31:0] count_value,
   output logic last,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [12:0] csr_data
);

   cwc_pkg::csr_type csr_ff;
   cwc_pkg::cmd_type q_cmd;
   logic q_valid, q_ready;

   assign csr_ready = 1'b1;

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.center_x <= 12'd236;
         csr_ff.center_y <= 12'd872;
         csr_ff.radius <= 13'd5000;
         csr_ff.angle_min <= 9'sd0;
         csr_ff.angle_max <= 9'sd180;
      end else if (csr_valid) begin
         unique case (csr_index)
            cwc_pkg::CSR_CENTER_X: csr_ff.center_x <= csr_data[11:0];
            cwc_pkg::CSR_CENTER_Y: csr_ff.center_y <= csr_data[11:0];
            cwc_pkg::CSR_RADIUS: csr_ff.radius <= csr_data;
            cwc_pkg::CSR_ANGLE_MIN: csr_ff.angle_min <= csr_data[8:0];
            cwc_pkg::CSR_ANGLE_MAX: csr_ff.angle_max <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   cwc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .file_number(file_number), .frame_number(frame_number),
      .pos_x(pos_x), .pos_y(pos_y), .axis_angle(axis_angle),
      .window_index(window_index), .window_low(window_low),
      .window_high(window_high), .flight_channel(flight_channel),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   cwc_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .csr(csr_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .count_kind(count_kind), .count_value(count_value), .last(last)
   );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNUSED_LAST = 3'd7;
   localparam int WatchdogLimit = 20000;
   localparam int SettleCycles = 100;

   typedef struct {
      logic [2:0] code;
      logic [15:0] file;
      logic [23:0] frame;
      logic [11:0] x;
      logic [11:0] y;
      logic signed [16:0] angle;
      logic [1:0] widx;
      logic [12:0] wlo;
      logic [12:0] whi;
      logic [15:0] chan;
   } request_type;

   typedef struct {
      logic [2:0] kind;
      logic [31:0] value;
      logic last;
   } count_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = '0;
   logic [15:0] file_number = '0;
   logic [23:0] frame_number = '0;
   logic [11:0] pos_x = '0;
   logic [11:0] pos_y = '0;
   logic signed [16:0] axis_angle = '0;
   logic [1:0] window_index = '0;
   logic [12:0] window_low = '0;
   logic [12:0] window_high = '0;
   logic [15:0] flight_channel = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] count_kind;
   logic [31:0] count_value;
   logic last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [12:0] csr_data = '0;

   coincidence_window_counter_core uut (.*);

   always #4 clock = ~clock;

   // Model state: the image table, the channel windows, the counters and the
   // acceptance settings, all as they stand after the items accepted so far.
   logic [39:0] image_key [cwc_pkg::TableDepth];
   logic [11:0] image_x [cwc_pkg::TableDepth];
   logic [11:0] image_y [cwc_pkg::TableDepth];
   int image_angle [cwc_pkg::TableDepth];
   int image_count = 0;
   int win_lo [cwc_pkg::NumWindows];
   int win_hi [cwc_pkg::NumWindows];
   logic [31:0] hit_count [cwc_pkg::NumWindows + 1];
   int cfg_cx = 236, cfg_cy = 872, cfg_radius = 5000, cfg_amin = 0, cfg_amax = 180;

   request_type req_backlog[$];
   count_type counts_due[$];
   int idle_pct = 23;
   bit failed = 1'b0;
   int items_sent = 0, counts_checked = 0, csr_writes = 0, quiet_cycles = 0;

   function automatic bit in_acceptance(int idx);
      longint dx, dy, r, a;
      dx = longint'(image_x[idx]) - cfg_cx;
      dy = longint'(image_y[idx]) - cfg_cy;
      r = cfg_radius;
      a = image_angle[idx];
      return a >= longint'(cfg_amin) * 256 && a < longint'(cfg_amax) * 256 &&
             dx * dx + dy * dy < r * r;
   endfunction

   function automatic logic [31:0] saturating_inc(logic [31:0] c);
      return (c == cwc_pkg::CountMax) ? c : c + 1;
   endfunction

   // Binary search as the hardware does it: the first equal key ends it, even
   // when the table was loaded out of order or with duplicates.
   function automatic bit flight_hits(logic [39:0] key);
      int left, right, mid;
      left = 0;
      right = image_count - 1;
      while (left <= right) begin
         mid = (left + right) / 2;
         if (image_key[mid] == key) return in_acceptance(mid);
         if (image_key[mid] < key) left = mid + 1;
         else right = mid - 1;
      end
      return 1'b0;
   endfunction

   task automatic predict_request(request_type r);
      logic [31:0] incident;
      int chan;
      count_type c;
      incident = '0;
      chan = r.chan;
      case (r.code)
         cwc_pkg::REQ_LOAD_ENTRY: begin
            if (image_count < cwc_pkg::TableDepth) begin
               image_key[image_count] = {r.file, r.frame};
               image_x[image_count] = r.x;
               image_y[image_count] = r.y;
               image_angle[image_count] = r.angle;
               image_count++;
            end
         end
         cwc_pkg::REQ_LOAD_WINDOW: begin
            win_lo[r.widx] = int'(r.wlo) * 8;
            win_hi[r.widx] = int'(r.whi) * 8;
         end
         cwc_pkg::REQ_FLIGHT: begin
            if (flight_hits({r.file, r.frame})) begin
               for (int k = 0; k < cwc_pkg::NumWindows; k++)
                  if (win_lo[k] <= chan && chan < win_hi[k])
                     hit_count[k] = saturating_inc(hit_count[k]);
               if (chan < int'(cwc_pkg::TotalWindowTop))
                  hit_count[cwc_pkg::NumWindows] =
                     saturating_inc(hit_count[cwc_pkg::NumWindows]);
            end
         end
         cwc_pkg::REQ_REPORT: begin
            for (int i = 0; i < image_count; i++)
               if (in_acceptance(i)) incident = saturating_inc(incident);
            c.kind = 3'd0;
            c.value = incident;
            c.last = 1'b0;
            counts_due = {counts_due, c};
            for (int k = 0; k <= cwc_pkg::NumWindows; k++) begin
               c.kind = 3'(k + 1);
               c.value = hit_count[k];
               c.last = (k == cwc_pkg::NumWindows);
               counts_due = {counts_due, c};
               hit_count[k] = '0;
            end
         end
         cwc_pkg::REQ_CLEAR_TABLE: image_count = 0;
         default: ;
      endcase
   endtask

   // Driver: valid rises only when an item is queued and the random gap allows
   // it, and it then holds with a steady payload until the block takes the item.
   always @(posedge clock) begin
      bit taken, drive;
      request_type r;
      if (!reset) begin
         taken = req_valid && req_ready;
         if (taken) begin
            predict_request(req_backlog.pop_front());
            items_sent++;
         end
         drive = req_valid && !taken;
         if (!drive && req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            drive = 1'b1;
            r = req_backlog[0];
            req_type <= r.code;
            file_number <= r.file;
            frame_number <= r.frame;
            pos_x <= r.x;
            pos_y <= r.y;
            axis_angle <= r.angle;
            window_index <= r.widx;
            window_low <= r.wlo;
            window_high <= r.whi;
            flight_channel <= r.chan;
         end
         req_valid <= drive;
      end
   end

   // Monitor: compares each accepted count with the oldest one predicted.
   always @(posedge clock) begin
      count_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            counts_checked++;
            if (counts_due.size() == 0) begin
               $display("%0t: unexpected count kind %0d value %0d", $time,
                        count_kind, count_value);
               failed = 1'b1;
            end else begin
               e = counts_due.pop_front();
               if (count_kind !== e.kind) begin
                  $display("%0t: count_kind expected %0d actual %0d", $time,
                           e.kind, count_kind);
                  failed = 1'b1;
               end
               if (count_value !== e.value) begin
                  $display("%0t: count_value (kind %0d) expected %0d actual %0d",
                           $time, e.kind, e.value, count_value);
                  failed = 1'b1;
               end
               if (last !== e.last) begin
                  $display("%0t: last (kind %0d) expected %0b actual %0b", $time,
                           e.kind, e.last, last);
                  failed = 1'b1;
               end
            end
         end
         rsp_ready <= $urandom_range(99) >= idle_pct;
      end
   end

   // Watchdog: ends the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // A request with every field random, so that unused fields toggle too.
   function automatic request_type any_request(logic [2:0] code);
      request_type r;
      r.code = code;
      r.file = 16'($urandom);
      r.frame = 24'($urandom);
      r.x = 12'($urandom);
      r.y = 12'($urandom);
      r.angle = 17'($urandom_range(92160) - 46080);
      r.widx = 2'($urandom);
      r.wlo = 13'($urandom);
      r.whi = 13'($urandom);
      r.chan = 16'($urandom);
      return r;
   endfunction

   task automatic queue_request(request_type r);
      req_backlog = {req_backlog, r};
   endtask

   task automatic add_entry(logic [39:0] key, logic [11:0] x, logic [11:0] y, int ang);
      request_type r;
      r = any_request(cwc_pkg::REQ_LOAD_ENTRY);
      {r.file, r.frame} = key;
      r.x = x;
      r.y = y;
      r.angle = 17'(ang);
      queue_request(r);
   endtask

   task automatic add_window(logic [1:0] w, logic [12:0] lo, logic [12:0] hi);
      request_type r;
      r = any_request(cwc_pkg::REQ_LOAD_WINDOW);
      r.widx = w;
      r.wlo = lo;
      r.whi = hi;
      queue_request(r);
   endtask

   task automatic add_flight(logic [39:0] key, logic [15:0] chan);
      request_type r;
      r = any_request(cwc_pkg::REQ_FLIGHT);
      {r.file, r.frame} = key;
      r.chan = chan;
      queue_request(r);
   endtask

   task automatic add_plain(logic [2:0] code);
      queue_request(any_request(code));
   endtask

   // Waits until every queued item is taken and every count has come back,
   // then lets loads and flights that cause no count finish inside the block.
   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || counts_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 13'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         cwc_pkg::CSR_CENTER_X: cfg_cx = value & 12'hFFF;
         cwc_pkg::CSR_CENTER_Y: cfg_cy = value & 12'hFFF;
         cwc_pkg::CSR_RADIUS: cfg_radius = value & 13'h1FFF;
         cwc_pkg::CSR_ANGLE_MIN: cfg_amin = int'($signed(9'(value)));
         cwc_pkg::CSR_ANGLE_MAX: cfg_amax = int'($signed(9'(value)));
         default: ;
      endcase
   endtask

   task automatic set_acceptance(int cx, int cy, int rad, int amin, int amax);
      wait_idle();
      write_reg(cwc_pkg::CSR_CENTER_X, cx);
      write_reg(cwc_pkg::CSR_CENTER_Y, cy);
      write_reg(cwc_pkg::CSR_RADIUS, rad);
      write_reg(cwc_pkg::CSR_ANGLE_MIN, amin);
      write_reg(cwc_pkg::CSR_ANGLE_MAX, amax);
   endtask

   // One well-formed pass: fresh sorted table, some windows, flights that
   // mostly name loaded keys, then a report. Now and then the table is loaded
   // out of order or with repeated keys.
   task automatic add_run();
      logic [39:0] keys[$];
      int n, flights, shape;
      logic [39:0] k;
      n = $urandom_range(24, 1);
      flights = $urandom_range(20, 4);
      shape = $urandom_range(9);
      add_plain(cwc_pkg::REQ_CLEAR_TABLE);
      for (int i = 0; i < n; i++) begin
         k = 40'({$urandom, $urandom});
         if (i > 0 && $urandom_range(9) == 0) k = keys[i - 1];
         else if ($urandom_range(3) == 0) k = {16'($urandom_range(3)), 24'($urandom_range(63))};
         keys = {keys, k};
      end
      if (shape != 0) keys.sort();
      else keys.shuffle();
      foreach (keys[i])
         add_entry(keys[i],
                   $urandom_range(99) < 70 ? 12'(cfg_cx + $urandom_range(600) - 300)
                                           : 12'($urandom),
                   $urandom_range(99) < 70 ? 12'(cfg_cy + $urandom_range(600) - 300)
                                           : 12'($urandom),
                   $urandom_range(92160) - 46080);
      repeat ($urandom_range(3))
         add_window(2'($urandom), 13'($urandom_range(8191)), 13'($urandom_range(8191)));
      repeat (flights) begin
         k = ($urandom_range(9) < 8) ? keys[$urandom_range(n - 1)]
                                     : 40'({$urandom, $urandom});
         add_flight(k, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000)));
      end
      if ($urandom_range(9) == 0)
         add_plain(3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST)));
      add_plain(cwc_pkg::REQ_REPORT);
   endtask

   initial begin
      logic [39:0] top_key;
      int before_count;
      top_key = {16'hFFFF, 24'hFFFFFF};
      for (int k = 0; k <= cwc_pkg::NumWindows; k++) hit_count[k] = '0;
      for (int k = 0; k < cwc_pkg::NumWindows; k++) begin
         win_lo[k] = 0;
         win_hi[k] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: empty table, window edge
      // cases, extreme keys, positions and angles, and channels at the
      // edges of the total window.
      add_flight('0, 16'd10);
      add_plain(cwc_pkg::REQ_REPORT);
      add_window(2'd0, 13'd0, 13'd8191);
      add_window(2'd1, 13'd100, 13'd50);
      add_window(2'd2, 13'd8191, 13'd8191);
      add_window(2'd3, 13'd0, 13'd8000);
      add_entry('0, 12'd236, 12'd872, 0);
      add_entry(40'h00_0100_0000, 12'd0, 12'd0, 180 * 256 - 1);
      add_entry(40'h12_3456_7890, 12'd4095, 12'd4095, -46080);
      add_entry(top_key, 12'd4095, 12'd0, 46080);
      add_flight('0, 16'd0);
      add_flight(40'h00_0100_0000, 16'd63999);
      add_flight(40'h12_3456_7890, 16'd64000);
      add_flight(top_key, 16'd65535);
      add_flight('0, 16'd65535);
      add_flight(40'h00_0000_0001, 16'd5);
      add_plain(REQ_UNUSED_FIRST);
      add_plain(REQ_UNUSED_LAST);
      add_plain(cwc_pkg::REQ_REPORT);
      add_plain(cwc_pkg::REQ_CLEAR_TABLE);
      add_plain(cwc_pkg::REQ_REPORT);

      // A fresh table built under the extreme settings, including an empty angle window.
      set_acceptance(0, 4095, 0, -180, 180);
      add_entry('0, 12'd0, 12'd4095, -46080);
      add_flight('0, 16'd1);
      add_plain(cwc_pkg::REQ_REPORT);
      set_acceptance(4095, 0, 8191, -180, 180);
      add_entry(top_key, 12'd0, 12'd4095, 0);
      add_flight(top_key, 16'd1);
      add_plain(cwc_pkg::REQ_REPORT);
      set_acceptance(2048, 2048, 8191, 180, -180);
      add_flight(top_key, 16'd1);
      add_plain(cwc_pkg::REQ_REPORT);

      // Random part: several settings, and a long stretch without gaps.
      set_acceptance(236, 872, 5000, 0, 180);
      before_count = items_sent;
      while (items_sent + req_backlog.size() - before_count < 450) begin
         if ($urandom_range(7) == 0)
            set_acceptance($urandom_range(4095), $urandom_range(4095),
                           $urandom_range(8191), $urandom_range(180) - 180,
                           $urandom_range(180));
         idle_pct = ((items_sent - before_count) % 300 > 150) ? 0 : 23;
         add_run();
         if ($urandom_range(4) == 0) add_flight(40'({$urandom, $urandom}), 16'($urandom));
         while (req_backlog.size() > 40) @(posedge clock);
      end
      idle_pct = 23;

      wait_idle();
      $display("Sent %0d requests, checked %0d counts, made %0d register writes,",
               items_sent, counts_checked, csr_writes);
      $display("covering sorted, unsorted, duplicate-key and empty tables under several settings.");
      if (!failed) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
